### sv/txuc_pkg.sv
// ----------------------------------------------------------------------------
// txuc_pkg
// Shared widths, register map, reset values and axis pipeline types for the
// touch sample unpack and calibration block.
// ----------------------------------------------------------------------------
package txuc_pkg;

  localparam int RAW_BITS       = 12;
  localparam int CFG_BITS       = 12;
  localparam int BYTE_BITS      = 8;
  localparam int WORD_BITS      = 3 * BYTE_BITS;
  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = CFG_BITS / DIV_STAGES;
  localparam int NUM_STAGES     = DIV_STAGES + 3;
  localparam int SAMPLE_BIT     = 4;
  localparam int ADDR_BITS      = 5;
  localparam int DATA_BITS      = 32;

  localparam logic [CFG_BITS-1:0] X_RAW_MIN_RST = 12'd70;
  localparam logic [CFG_BITS-1:0] X_RAW_MAX_RST = 12'd3990;
  localparam logic [CFG_BITS-1:0] Y_RAW_MIN_RST = 12'd3890;
  localparam logic [CFG_BITS-1:0] Y_RAW_MAX_RST = 12'd150;
  localparam logic [CFG_BITS-1:0] X_RANGE_RST   = 12'd799;
  localparam logic [CFG_BITS-1:0] Y_RANGE_RST   = 12'd479;

  typedef enum logic [2:0] {
    REG_DEVICE_PRESENT,
    REG_X_RAW_MIN,
    REG_X_RAW_MAX,
    REG_Y_RAW_MIN,
    REG_Y_RAW_MAX,
    REG_X_RANGE,
    REG_Y_RANGE
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_DIV
  } axis_mode_e;

  typedef struct packed {
    axis_mode_e          mode;
    logic [CFG_BITS-1:0] d;
    logic [CFG_BITS-1:0] rng;
    logic [CFG_BITS-1:0] rem;
    logic [CFG_BITS-1:0] low;
    logic [CFG_BITS-1:0] quo;
  } axis_stage_t;

endpackage

### sv/txuc_axis.sv
// ----------------------------------------------------------------------------
// txuc_axis
// One calibrated axis: span classification, offset times range product, then
// a restoring divider spread over several stages, and a final select.
// ----------------------------------------------------------------------------
module txuc_axis import txuc_pkg::*; (
  input  logic                  clk_i,
  input  logic [NUM_STAGES-1:0] en_i,
  input  logic [RAW_BITS-1:0]   raw_i,
  input  logic [CFG_BITS-1:0]   span_start_i,
  input  logic [CFG_BITS-1:0]   span_end_i,
  input  logic [CFG_BITS-1:0]   range_i,
  output logic [CFG_BITS-1:0]   pos_o
);

  logic [CFG_BITS-1:0] raw;
  logic [CFG_BITS-1:0] off_d, d_d;
  axis_mode_e          mode_d;

  axis_mode_e          mode0_q;
  logic [CFG_BITS-1:0] off0_q, d0_q, rng0_q;

  axis_stage_t         st_q [DIV_STAGES+1];
  axis_stage_t         mul_d;
  logic [2*CFG_BITS-1:0] prod;
  logic [CFG_BITS-1:0] pos_d, pos_q;

  assign raw = CFG_BITS'(raw_i);

  // classify the raw value against the span
  always_comb begin
    if (span_start_i < span_end_i) begin
      d_d   = span_end_i - span_start_i;
      off_d = raw - span_start_i;
      if (raw < span_start_i) begin
        mode_d = MODE_ZERO;
      end else if (off_d > d_d) begin
        mode_d = MODE_FULL;
      end else begin
        mode_d = MODE_DIV;
      end
    end else begin
      d_d   = span_start_i - span_end_i;
      off_d = span_start_i - raw;
      if (raw >= span_start_i) begin
        mode_d = MODE_ZERO;
      end else if (off_d > d_d || d_d == '0) begin
        mode_d = MODE_FULL;
      end else begin
        mode_d = MODE_DIV;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mode0_q <= mode_d;
      off0_q  <= off_d;
      d0_q    <= d_d;
      rng0_q  <= range_i;
    end
  end

  assign prod = (2*CFG_BITS)'(off0_q) * (2*CFG_BITS)'(rng0_q);

  always_comb begin
    mul_d.mode = mode0_q;
    mul_d.d    = d0_q;
    mul_d.rng  = rng0_q;
    mul_d.rem  = prod[2*CFG_BITS-1:CFG_BITS];
    mul_d.low  = prod[CFG_BITS-1:0];
    mul_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      st_q[0] <= mul_d;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    axis_stage_t nxt;

    always_comb begin
      logic [CFG_BITS:0] t;
      nxt = st_q[k-1];
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
        t       = {nxt.rem, nxt.low[CFG_BITS-1]};
        nxt.low = {nxt.low[CFG_BITS-2:0], 1'b0};
        if (t >= {1'b0, nxt.d}) begin
          nxt.rem = CFG_BITS'(t - {1'b0, nxt.d});
          nxt.quo = {nxt.quo[CFG_BITS-2:0], 1'b1};
        end else begin
          nxt.rem = t[CFG_BITS-1:0];
          nxt.quo = {nxt.quo[CFG_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k+1]) begin
        st_q[k] <= nxt;
      end
    end
  end

  always_comb begin
    case (st_q[DIV_STAGES].mode)
      MODE_ZERO: pos_d = '0;
      MODE_FULL: pos_d = st_q[DIV_STAGES].rng;
      MODE_DIV:  pos_d = st_q[DIV_STAGES].quo;
      default:   pos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NUM_STAGES-1]) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

### sv/touch_xyz_unpack_calibrate.sv
// ----------------------------------------------------------------------------
// touch_xyz_unpack_calibrate
// Unpack a touch sample word and map raw X and Y onto screen coordinates.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless out_ready_i stalls the output; the
// per-axis divider is four stages of three quotient bits each, behind a
// classify stage and a multiply stage.
// Words without a sample, or with no device, are taken and dropped.
// Reset: pipeline emptied, registers return to their default calibration.
module touch_xyz_unpack_calibrate import txuc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           fifo_status_i,
  input  logic [7:0]           sample_byte0_i,
  input  logic [7:0]           sample_byte1_i,
  input  logic [7:0]           sample_byte2_i,
  input  logic [7:0]           sample_byte3_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [11:0]          x_pos_o,
  output logic [11:0]          y_pos_o,
  output logic [7:0]           pressure_o
);

  logic                dev_q;
  logic [CFG_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q, x_range_q, y_range_q;
  reg_idx_e            reg_idx;
  logic                cfg_wr;

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] rdy;
  logic [BYTE_BITS-1:0]  p_q [NUM_STAGES];

  logic [WORD_BITS-1:0] word;
  logic [RAW_BITS-1:0]  raw_x, raw_y;
  logic                 take;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q     <= 1'b0;
      x_min_q   <= X_RAW_MIN_RST;
      x_max_q   <= X_RAW_MAX_RST;
      y_min_q   <= Y_RAW_MIN_RST;
      y_max_q   <= Y_RAW_MAX_RST;
      x_range_q <= X_RANGE_RST;
      y_range_q <= Y_RANGE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEVICE_PRESENT: dev_q     <= pwdata[0];
        REG_X_RAW_MIN:      x_min_q   <= pwdata[CFG_BITS-1:0];
        REG_X_RAW_MAX:      x_max_q   <= pwdata[CFG_BITS-1:0];
        REG_Y_RAW_MIN:      y_min_q   <= pwdata[CFG_BITS-1:0];
        REG_Y_RAW_MAX:      y_max_q   <= pwdata[CFG_BITS-1:0];
        REG_X_RANGE:        x_range_q <= pwdata[CFG_BITS-1:0];
        REG_Y_RANGE:        y_range_q <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEVICE_PRESENT: prdata = DATA_BITS'(dev_q);
      REG_X_RAW_MIN:      prdata = DATA_BITS'(x_min_q);
      REG_X_RAW_MAX:      prdata = DATA_BITS'(x_max_q);
      REG_Y_RAW_MIN:      prdata = DATA_BITS'(y_min_q);
      REG_Y_RAW_MAX:      prdata = DATA_BITS'(y_max_q);
      REG_X_RANGE:        prdata = DATA_BITS'(x_range_q);
      REG_Y_RANGE:        prdata = DATA_BITS'(y_range_q);
      default:            prdata = '0;
    endcase
  end

  // advance a stage when it is empty or the one after it moves
  always_comb begin
    rdy[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];
  assign take       = in_valid_i && dev_q && fifo_status_i[SAMPLE_BIT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= take;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p_q[0] <= sample_byte3_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        p_q[k] <= p_q[k-1];
      end
    end
  end

  assign word  = {sample_byte0_i, sample_byte1_i, sample_byte2_i};
  assign raw_x = word[RAW_BITS +: RAW_BITS];
  assign raw_y = word[RAW_BITS-1:0];

  txuc_axis u_axis_x (
    .clk_i        (clk_i),
    .en_i         (rdy),
    .raw_i        (raw_x),
    .span_start_i (x_min_q),
    .span_end_i   (x_max_q),
    .range_i      (x_range_q),
    .pos_o        (x_pos_o)
  );

  txuc_axis u_axis_y (
    .clk_i        (clk_i),
    .en_i         (rdy),
    .raw_i        (raw_y),
    .span_start_i (y_min_q),
    .span_end_i   (y_max_q),
    .range_i      (y_range_q),
    .pos_o        (y_pos_o)
  );

  assign out_valid_o = v_q[NUM_STAGES-1];
  assign pressure_o  = p_q[NUM_STAGES-1];

  a_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> x_pos_o <= x_range_q)
    else $error("x_pos beyond x_range");

  a_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> y_pos_o <= y_range_q)
    else $error("y_pos beyond y_range");

  a_drop_no_device: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !dev_q) |=> !v_q[0])
    else $error("word entered pipeline with no device");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NUM_STAGES-1] && !out_ready_i) |=> !in_ready_o || !(&v_q[NUM_STAGES-2:0])
      || v_q[NUM_STAGES-1])
    else $error("stalled result lost");

endmodule
